FILE: hdl/dre_pkg.sv
// Shared types and constants for the dirty range delta encoder.
package dre_pkg;

    localparam int MAX_BLOCK_BYTES = 256;
    localparam int MAP_BYTES       = (MAX_BLOCK_BYTES + 7) / 8;
    localparam int SHADOW_DEPTH    = MAX_BLOCK_BYTES + MAP_BYTES;
    localparam int BLK_AW          = $clog2(MAX_BLOCK_BYTES);
    localparam int SHD_AW          = $clog2(SHADOW_DEPTH);

    // configuration register indexes
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 9;
    localparam bit [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd0;
    localparam bit [CFG_IDX_W-1:0] REG_BIDIR       = 1'd1;

    // operation codes
    localparam bit [2:0] OP_WRITE      = 3'd0;
    localparam bit [2:0] OP_INVALIDATE = 3'd1;
    localparam bit [2:0] OP_SYNC       = 3'd2;
    localparam bit [2:0] OP_READ       = 3'd3;
    localparam bit [2:0] OP_RELEASE    = 3'd4;

    // status codes
    localparam bit [1:0] ST_DONE     = 2'd0;
    localparam bit [1:0] ST_NOCHANGE = 2'd1;
    localparam bit [1:0] ST_BUSY     = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [8:0] address;
        logic [7:0] range_end;
        logic [7:0] write_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] status;
        logic [7:0] frame_start;
        logic [7:0] frame_end;
        logic       keyframe;
        logic [8:0] bitmap_start;
        logic [8:0] bitmap_end;
    } out_t;

endpackage

FILE: hdl/dirty_range_delta_encoder.sv
// Top level: sequencer and byte datapath of the dirty range delta encoder.
// One request at a time; each gives exactly one result. After reset a clearing pass
// zeroes the three memories and no request is taken meanwhile. Write, release, plain
// invalidate and early-exit synchronize answer straight from idle; an in-range read delta
// first waits in S_RD_WAIT for the registered read data. Bidirectional invalidate reads and
// writes back each bitmap byte it touches. Synchronize spends a read state and a compare or
// write state on each byte it visits. In trim mode the forward and backward scans and the
// difference/copy pass together visit the dirty range about once. In bidirectional mode the
// frame pass covers the range and the bitmap move adds up to 32 bytes. The longest case is a
// bidirectional keyframe over the whole block and its bitmap. The single registered read
// port of each memory paces every pass. Config writes land on the cycle they are given.
module dirty_range_delta_encoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dre_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dre_pkg::out_t                    m_data,
    input  logic                             cfg_we,
    input  logic [dre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dre_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int BAW = dre_pkg::BLK_AW;
    localparam int SAW = dre_pkg::SHD_AW;
    localparam bit [SAW-1:0] SHD_LAST = SAW'(dre_pkg::SHADOW_DEPTH - 1);
    localparam bit [8:0] NB_MAX = 9'(dre_pkg::MAX_BLOCK_BYTES);

    // sequencer states
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INV_RD  = 4'd2;
    localparam logic [3:0] S_INV_WR  = 4'd3;
    localparam logic [3:0] S_RD_WAIT = 4'd4;
    localparam logic [3:0] S_FWD_RD  = 4'd5;
    localparam logic [3:0] S_FWD_CMP = 4'd6;
    localparam logic [3:0] S_BWD_RD  = 4'd7;
    localparam logic [3:0] S_BWD_CMP = 4'd8;
    localparam logic [3:0] S_COPY_RD = 4'd9;
    localparam logic [3:0] S_COPY_WR = 4'd10;
    localparam logic [3:0] S_MAP_RD  = 4'd11;
    localparam logic [3:0] S_MAP_WR  = 4'd12;

    logic [3:0]     state_reg, state_next;
    logic [SAW-1:0] i_reg, i_next;
    logic [4:0]     b_reg, b_next;
    logic [7:0]     s_reg, s_next;
    logic [7:0]     e_reg, e_next;
    logic [SAW-1:0] mend_reg, mend_next;
    logic [7:0]     dlow_reg, dlow_next;
    logic [7:0]     dhigh_reg, dhigh_next;
    logic           dvalid_reg, dvalid_next;
    logic           wantkey_reg, wantkey_next;
    logic           pending_reg, pending_next;
    logic           iskey_reg, iskey_next;
    logic [8:0]     bytes_reg, bytes_next;
    logic           bidir_reg, bidir_next;
    logic           mvalid_reg, mvalid_next;
    dre_pkg::out_t  res_reg, res_next;

    // memory ports
    logic           blk_we, shd_we, dlt_we;
    logic [BAW-1:0] blk_waddr;
    logic [SAW-1:0] shd_waddr, dlt_waddr;
    logic [7:0]     blk_wdata, shd_wdata, dlt_wdata;
    logic [7:0]     blk_rd, shd_rd, dlt_rd;

    logic           accept;
    logic [8:0]     nb;
    logic [7:0]     nb_m1;
    logic [7:0]     inv_s, inv_e, sync_hi;
    logic [7:0]     byte_diff;
    logic           bytes_eq;
    logic [7:0]     mark_mask;
    logic [8:0]     addr_bit;
    logic [SAW-1:0] map_p0, map_p1;
    dre_pkg::out_t  res_zero, res_sync;

    dre_ram #(.DEPTH(dre_pkg::MAX_BLOCK_BYTES), .AW(BAW)) u_blk (
        .aclk(aclk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
        .raddr(i_reg[BAW-1:0]), .rdata(blk_rd)
    );

    dre_ram #(.DEPTH(dre_pkg::SHADOW_DEPTH), .AW(SAW)) u_shd (
        .aclk(aclk), .we(shd_we), .waddr(shd_waddr), .wdata(shd_wdata),
        .raddr(i_reg), .rdata(shd_rd)
    );

    dre_ram #(.DEPTH(dre_pkg::SHADOW_DEPTH), .AW(SAW)) u_dlt (
        .aclk(aclk), .we(dlt_we), .waddr(dlt_waddr), .wdata(dlt_wdata),
        .raddr(s_data.address), .rdata(dlt_rd)
    );

    assign s_ready = (state_reg == S_IDLE) && (!mvalid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = mvalid_reg;
    assign m_data  = res_reg;

    // effective block size, saturated to 1..max
    always_comb begin
        if (bytes_reg == 9'd0) begin
            nb = 9'd1;
        end else if (bytes_reg > NB_MAX) begin
            nb = NB_MAX;
        end else begin
            nb = bytes_reg;
        end
    end
    assign nb_m1 = 8'(nb - 9'd1);

    assign inv_s   = s_data.address[7:0];
    assign inv_e   = (s_data.range_end > nb_m1) ? nb_m1 : s_data.range_end;
    assign sync_hi = (dhigh_reg > nb_m1) ? nb_m1 : dhigh_reg;

    // shared byte unit
    assign byte_diff = blk_rd - shd_rd;
    assign bytes_eq  = (blk_rd == shd_rd);

    // bits of the current bitmap byte that fall inside the invalidated range
    always_comb begin
        addr_bit = '0;
        for (int k = 0; k < 8; k++) begin
            addr_bit     = {1'b0, b_reg, 3'(k)};
            mark_mask[k] = (addr_bit >= {1'b0, s_reg}) && (addr_bit <= {1'b0, e_reg});
        end
    end

    assign map_p0 = SAW'(nb + {4'd0, s_reg[7:3]});
    assign map_p1 = SAW'(nb + {4'd0, e_reg[7:3]});

    always_comb begin
        res_zero = '0;
        res_sync              = '0;
        res_sync.status       = dre_pkg::ST_DONE;
        res_sync.frame_start  = s_reg;
        res_sync.frame_end    = e_reg;
        res_sync.keyframe     = iskey_reg;
        res_sync.bitmap_start = bidir_reg ? 9'(map_p0) : 9'd0;
        res_sync.bitmap_end   = bidir_reg ? 9'(map_p1) : 9'd0;
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        b_next       = b_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        mend_next    = mend_reg;
        dlow_next    = dlow_reg;
        dhigh_next   = dhigh_reg;
        dvalid_next  = dvalid_reg;
        wantkey_next = wantkey_reg;
        pending_next = pending_reg;
        iskey_next   = iskey_reg;
        bytes_next   = bytes_reg;
        bidir_next   = bidir_reg;
        mvalid_next  = mvalid_reg && !m_ready;
        res_next     = res_reg;
        blk_we       = 1'b0;
        blk_waddr    = i_reg[BAW-1:0];
        blk_wdata    = '0;
        shd_we       = 1'b0;
        shd_waddr    = i_reg;
        shd_wdata    = '0;
        dlt_we       = 1'b0;
        dlt_waddr    = i_reg;
        dlt_wdata    = '0;

        if (cfg_we) begin
            if (cfg_index == dre_pkg::REG_BLOCK_BYTES) begin
                bytes_next = cfg_wdata;
            end else begin
                bidir_next = cfg_wdata[0];
            end
        end

        unique case (state_reg)
            S_CLR: begin
                blk_we = (i_reg < SAW'(dre_pkg::MAX_BLOCK_BYTES));
                shd_we = 1'b1;
                dlt_we = 1'b1;
                if (i_reg == SHD_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_next    = res_zero;
                    mvalid_next = 1'b1;
                    unique case (s_data.operation)
                        dre_pkg::OP_WRITE: begin
                            if (s_data.address < nb) begin
                                blk_we    = 1'b1;
                                blk_waddr = s_data.address[BAW-1:0];
                                blk_wdata = s_data.write_byte;
                            end
                        end
                        dre_pkg::OP_INVALIDATE: begin
                            if (s_data.address < nb) begin
                                if (!dvalid_reg) begin
                                    dlow_next   = inv_s;
                                    dhigh_next  = inv_e;
                                    dvalid_next = 1'b1;
                                end else begin
                                    if (inv_s < dlow_reg) dlow_next = inv_s;
                                    if (inv_e > dhigh_reg) dhigh_next = inv_e;
                                end
                                if (bidir_reg && inv_s <= inv_e) begin
                                    mvalid_next = 1'b0;
                                    s_next      = inv_s;
                                    e_next      = inv_e;
                                    b_next      = inv_s[7:3];
                                    i_next      = SAW'(nb + {4'd0, inv_s[7:3]});
                                    state_next  = S_INV_RD;
                                end
                            end
                        end
                        dre_pkg::OP_SYNC: begin
                            if (pending_reg || (!dvalid_reg && !wantkey_reg)) begin
                                res_next.status = (pending_reg && dvalid_reg) ?
                                    dre_pkg::ST_BUSY : dre_pkg::ST_NOCHANGE;
                            end else begin
                                dvalid_next = 1'b0;
                                if (wantkey_reg) begin
                                    mvalid_next  = 1'b0;
                                    wantkey_next = 1'b0;
                                    iskey_next   = 1'b1;
                                    s_next       = 8'd0;
                                    e_next       = nb_m1;
                                    i_next       = '0;
                                    state_next   = S_COPY_RD;
                                end else if (dlow_reg > sync_hi) begin
                                    res_next.status = dre_pkg::ST_NOCHANGE;
                                end else begin
                                    mvalid_next = 1'b0;
                                    s_next      = dlow_reg;
                                    e_next      = sync_hi;
                                    i_next      = {1'b0, dlow_reg};
                                    if (bidir_reg) begin
                                        iskey_next = 1'b0;
                                        state_next = S_COPY_RD;
                                    end else begin
                                        state_next = S_FWD_RD;
                                    end
                                end
                            end
                        end
                        dre_pkg::OP_READ: begin
                            if (s_data.address <= SHD_LAST) begin
                                mvalid_next = 1'b0;
                                state_next  = S_RD_WAIT;
                            end
                        end
                        dre_pkg::OP_RELEASE: begin
                            pending_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INV_RD: begin
                state_next = S_INV_WR;
            end
            S_INV_WR: begin
                shd_we    = 1'b1;
                shd_wdata = shd_rd | mark_mask;
                if (b_reg == e_reg[7:3]) begin
                    res_next    = res_zero;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    b_next     = b_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_INV_RD;
                end
            end
            S_RD_WAIT: begin
                res_next           = res_zero;
                res_next.read_byte = dlt_rd;
                mvalid_next        = 1'b1;
                state_next         = S_IDLE;
            end
            // trim unchanged bytes at the low end
            S_FWD_RD: begin
                state_next = S_FWD_CMP;
            end
            S_FWD_CMP: begin
                if (!bytes_eq) begin
                    s_next     = i_reg[7:0];
                    i_next     = {1'b0, e_reg};
                    state_next = S_BWD_RD;
                end else if (i_reg[7:0] == e_reg) begin
                    res_next        = res_zero;
                    res_next.status = dre_pkg::ST_NOCHANGE;
                    mvalid_next     = 1'b1;
                    state_next      = S_IDLE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FWD_RD;
                end
            end
            // trim unchanged bytes at the high end; a changed byte exists at s
            S_BWD_RD: begin
                state_next = S_BWD_CMP;
            end
            S_BWD_CMP: begin
                if (!bytes_eq) begin
                    e_next     = i_reg[7:0];
                    i_next     = {1'b0, s_reg};
                    iskey_next = 1'b0;
                    state_next = S_COPY_RD;
                end else begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_BWD_RD;
                end
            end
            // frame pass: delta out, shadow updated
            S_COPY_RD: begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR: begin
                dlt_we    = 1'b1;
                dlt_wdata = iskey_reg ? blk_rd : byte_diff;
                shd_we    = 1'b1;
                shd_wdata = blk_rd;
                if (i_reg[7:0] == e_reg) begin
                    pending_next = 1'b1;
                    if (bidir_reg) begin
                        i_next     = map_p0;
                        mend_next  = map_p1;
                        state_next = S_MAP_RD;
                    end else begin
                        res_next    = res_sync;
                        mvalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            // move bitmap slice into the frame and clear it
            S_MAP_RD: begin
                state_next = S_MAP_WR;
            end
            S_MAP_WR: begin
                dlt_we    = 1'b1;
                dlt_wdata = shd_rd;
                shd_we    = 1'b1;
                shd_wdata = 8'd0;
                if (i_reg == mend_reg) begin
                    res_next    = res_sync;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_MAP_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            i_reg       <= '0;
            dlow_reg    <= '0;
            dhigh_reg   <= '0;
            dvalid_reg  <= 1'b0;
            wantkey_reg <= 1'b1;
            pending_reg <= 1'b0;
            iskey_reg   <= 1'b0;
            bytes_reg   <= NB_MAX;
            bidir_reg   <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            dlow_reg    <= dlow_next;
            dhigh_reg   <= dhigh_next;
            dvalid_reg  <= dvalid_next;
            wantkey_reg <= wantkey_next;
            pending_reg <= pending_next;
            iskey_reg   <= iskey_next;
            bytes_reg   <= bytes_next;
            bidir_reg   <= bidir_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        b_reg    <= b_next;
        s_reg    <= s_next;
        e_reg    <= e_next;
        mend_reg <= mend_next;
        res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");

    a_clr_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> !mvalid_reg)
        else $error("result during clearing pass");

    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_COPY_WR |-> i_reg <= {1'b0, e_reg})
        else $error("frame pass beyond its end");

    a_result_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && state_reg != S_CLR) |-> !mvalid_reg)
        else $error("result held while a request is in work");
`endif

endmodule

FILE: hdl/dre_ram.sv
// Byte memory with one write port and one registered read port.
module dre_ram #(
    parameter int DEPTH = dre_pkg::SHADOW_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
